// ===== rtl/vad_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector address decoder package
// Shared widths, reset values, register indexes and the command record that
// travels from the decode front to the execute back.
// ----------------------------------------------------------------------------
package vad_pkg;

    // Field widths
    localparam int BYTE_W     = 7;
    localparam int DATA_W     = 5;
    localparam int COUNT_W    = 3;
    localparam int DIR_W      = 4;
    localparam int KIND_W     = 2;
    localparam int POS_W      = 12;
    localparam int INTEN_W    = 7;
    localparam int STYLE_W    = 3;
    localparam int GLOW_W     = 8;
    localparam int TAG_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Default depth of the command queue
    localparam int QUEUE_DEPTH = 2;

    // Reset values
    localparam logic [POS_W-1:0]   HOME_Y          = 12'd3032;
    localparam logic [POS_W-1:0]   HOME_X          = 12'd0;
    localparam logic [INTEN_W-1:0] RST_INTENSITY   = 7'd127;
    localparam logic [GLOW_W-1:0]  RST_NORMAL_GLOW = 8'd1;
    localparam logic [GLOW_W-1:0]  RST_THROUGH_GLOW = 8'd5;
    localparam logic [STYLE_W-1:0] STYLE_MAX       = 3'd4;

    // Record kinds
    localparam logic [KIND_W-1:0] KIND_MOVE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POINT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_DOWN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_STYLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFOCUS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THROUGH_MODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_GLOW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THROUGH_GLOW  = 3'd6;

    // Command classes produced by the front
    typedef enum logic [1:0] {
        CMD_ADDR = 2'd0,
        CMD_STEP = 2'd1,
        CMD_BAD  = 2'd2
    } t_cmd_op;

    // Classified request: new position = (old & keep) | set for address loads
    typedef struct packed {
        t_cmd_op            op;
        logic [POS_W-1:0]   keep_y;
        logic [POS_W-1:0]   set_y;
        logic [POS_W-1:0]   keep_x;
        logic [POS_W-1:0]   set_x;
        logic [DIR_W-1:0]   dir;
        logic [KIND_W-1:0]  kind;
    } t_cmd;

    // Display record held in the output register
    typedef struct packed {
        logic               valid_res;
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   pos_x;
        logic [INTEN_W-1:0] intensity;
        logic [STYLE_W-1:0] style;
        logic [GLOW_W-1:0]  glow;
        logic               defocus;
        logic               through_mode;
    } t_rec;

endpackage

// ===== rtl/vad_if.sv =====
// ----------------------------------------------------------------------------
// Vector address decoder channels
// Request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface vad_req_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [vad_pkg::COUNT_W-1:0]  byte_count;
    logic [vad_pkg::BYTE_W-1:0]   addr_byte0;
    logic [vad_pkg::BYTE_W-1:0]   addr_byte1;
    logic [vad_pkg::BYTE_W-1:0]   addr_byte2;
    logic [vad_pkg::BYTE_W-1:0]   addr_byte3;
    logic [vad_pkg::BYTE_W-1:0]   addr_byte4;
    logic [vad_pkg::DIR_W-1:0]    step_dir;
    logic [vad_pkg::KIND_W-1:0]   vector_kind;

    modport source (output valid, opcode, byte_count, addr_byte0, addr_byte1,
                    addr_byte2, addr_byte3, addr_byte4, step_dir, vector_kind,
                    input ready);
    modport sink   (input valid, opcode, byte_count, addr_byte0, addr_byte1,
                    addr_byte2, addr_byte3, addr_byte4, step_dir, vector_kind,
                    output ready);
endinterface

interface vad_res_if;
    logic                         valid;
    logic                         ready;
    logic                         valid_res;
    logic [vad_pkg::KIND_W-1:0]   kind;
    logic [vad_pkg::POS_W-1:0]    pos_y;
    logic [vad_pkg::POS_W-1:0]    pos_x;
    logic [vad_pkg::INTEN_W-1:0]  rec_intensity;
    logic [vad_pkg::STYLE_W-1:0]  rec_style;
    logic [vad_pkg::GLOW_W-1:0]   glow_count;
    logic                         rec_defocus;
    logic                         rec_through_mode;

    modport source (output valid, valid_res, kind, pos_y, pos_x, rec_intensity,
                    rec_style, glow_count, rec_defocus, rec_through_mode,
                    input ready);
    modport sink   (input valid, valid_res, kind, pos_y, pos_x, rec_intensity,
                    rec_style, glow_count, rec_defocus, rec_through_mode,
                    output ready);
endinterface

interface vad_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [vad_pkg::CFG_IDX_W-1:0]   index;
    logic [vad_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/vector_address_decoder.sv =====
// A request is written into the command queue, and its record into the output register
// when the back takes the command. Throughput: one request per cycle while the queue
// has room; one queued command a cycle while the output register is free or drained.
// A result left waiting does not stop intake until the command queue fills.
// Reset (synchronous, active low) empties the queue and output register, puts the
// beam at row 3032, column 0, and loads the register defaults.
// ----------------------------------------------------------------------------
// Vector address decoder
// Decodes vector address byte groups and step requests into display records.
// ----------------------------------------------------------------------------
module vector_address_decoder #(
    parameter int QUEUE_DEPTH = vad_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vad_req_if.sink     i_req,
    vad_cfg_if.sink     i_cfg,
    vad_res_if.source   o_res
);

    logic           w_front_valid;
    logic           w_front_ready;
    vad_pkg::t_cmd  w_front_cmd;
    logic           w_back_valid;
    logic           w_back_ready;
    vad_pkg::t_cmd  w_back_cmd;

    // Decode and classify
    vad_front u_front (
        .i_req       (i_req),
        .o_cmd_valid (w_front_valid),
        .i_cmd_ready (w_front_ready),
        .o_cmd       (w_front_cmd)
    );

    // Decouple front and back
    vad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_data  (w_front_cmd),
        .o_pop_valid  (w_back_valid),
        .i_pop_ready  (w_back_ready),
        .o_pop_data   (w_back_cmd)
    );

    // Execute and present records
    vad_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_back_valid),
        .o_cmd_ready (w_back_ready),
        .i_cmd       (w_back_cmd),
        .i_cfg       (i_cfg),
        .o_res       (o_res)
    );

endmodule

// ===== rtl/vad_front.sv =====
// ----------------------------------------------------------------------------
// Vector address decoder front
// Accepts requests, builds the byte tag and classifies each request into a
// keep/set command for the position, a step, or an unrecognised group.
// ----------------------------------------------------------------------------
module vad_front (
    vad_req_if.sink               i_req,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output vad_pkg::t_cmd         o_cmd
);

    localparam int PW = vad_pkg::POS_W;

    // Recognised tag patterns
    localparam logic [vad_pkg::TAG_W-1:0] TAG_FULL        = 10'h1F6;
    localparam logic [vad_pkg::TAG_W-1:0] TAG_TEN         = 10'h076;
    localparam logic [vad_pkg::TAG_W-1:0] TAG_HY_LX       = 10'h006;
    localparam logic [vad_pkg::TAG_W-1:0] TAG_LY_LX       = 10'h00E;
    localparam logic [vad_pkg::TAG_W-1:0] TAG_LY_HX_LX    = 10'h036;
    localparam logic [vad_pkg::TAG_W-1:0] TAG_LX          = 10'h002;
    localparam logic [vad_pkg::TAG_W-1:0] TAG_EX_LY_LX    = 10'h03E;
    localparam logic [vad_pkg::TAG_W-1:0] TAG_HY_LY_LX    = 10'h01E;
    localparam logic [vad_pkg::TAG_W-1:0] TAG_EX_LY_HX_LX = 10'h0F6;
    localparam logic [vad_pkg::TAG_W-1:0] TAG_HY_EX_LY_LX = 10'h07E;
    localparam logic [vad_pkg::TAG_W-1:0] TAG_HY_HX_LX    = 10'h016;

    // Keep masks for partial updates
    localparam logic [PW-1:0] KEEP_NONE  = 12'h000;
    localparam logic [PW-1:0] KEEP_ALL   = 12'hFFF;
    localparam logic [PW-1:0] KEEP_NO_LO = 12'hF83;
    localparam logic [PW-1:0] KEEP_NO_HI = 12'h07F;
    localparam logic [PW-1:0] KEEP_EX    = 12'h003;
    localparam logic [PW-1:0] KEEP_HI    = 12'hF80;

    localparam int NUM_BYTES = 5;

    logic [vad_pkg::BYTE_W-1:0] w_byte [NUM_BYTES];
    logic [vad_pkg::DATA_W-1:0] w_d    [NUM_BYTES];
    logic [vad_pkg::TAG_W-1:0]  w_tag;
    logic                       w_cnt_ok;

    // Field placement helpers
    function automatic logic [PW-1:0] f_hi(input logic [vad_pkg::DATA_W-1:0] d);
        return {d, 7'b0};
    endfunction

    function automatic logic [PW-1:0] f_lo(input logic [vad_pkg::DATA_W-1:0] d);
        return {5'b0, d, 2'b0};
    endfunction

    function automatic logic [PW-1:0] f_ex_y(input logic [vad_pkg::DATA_W-1:0] d);
        return {9'b0, d[4:2]};
    endfunction

    function automatic logic [PW-1:0] f_ex_x(input logic [vad_pkg::DATA_W-1:0] d);
        return {10'b0, d[1:0]};
    endfunction

    assign w_byte[0] = i_req.addr_byte0;
    assign w_byte[1] = i_req.addr_byte1;
    assign w_byte[2] = i_req.addr_byte2;
    assign w_byte[3] = i_req.addr_byte3;
    assign w_byte[4] = i_req.addr_byte4;

    // Split data bits and join the tag bits of the counted bytes
    always_comb begin
        w_tag = '0;
        for (int i = 0; i < NUM_BYTES; i++) begin
            w_d[i] = w_byte[i][vad_pkg::DATA_W-1:0];
            if (vad_pkg::COUNT_W'(i) < i_req.byte_count) begin
                w_tag = {w_tag[vad_pkg::TAG_W-3:0], w_byte[i][6:5]};
            end
        end
    end

    assign w_cnt_ok = (i_req.byte_count != '0) &&
                      (i_req.byte_count <= vad_pkg::COUNT_W'(NUM_BYTES));

    // Classify the request
    always_comb begin
        o_cmd.op     = vad_pkg::CMD_ADDR;
        o_cmd.keep_y = KEEP_ALL;
        o_cmd.set_y  = '0;
        o_cmd.keep_x = KEEP_ALL;
        o_cmd.set_x  = '0;
        o_cmd.dir    = i_req.step_dir;
        o_cmd.kind   = i_req.vector_kind;
        if (i_req.opcode) begin
            o_cmd.op = vad_pkg::CMD_STEP;
        end else if (!w_cnt_ok) begin
            o_cmd.op = vad_pkg::CMD_BAD;
        end else begin
            case (w_tag)
                TAG_FULL: begin
                    o_cmd.keep_y = KEEP_NONE;
                    o_cmd.set_y  = f_hi(w_d[0]) | f_lo(w_d[2]) | f_ex_y(w_d[1]);
                    o_cmd.keep_x = KEEP_NONE;
                    o_cmd.set_x  = f_hi(w_d[3]) | f_lo(w_d[4]) | f_ex_x(w_d[1]);
                end
                TAG_TEN: begin
                    o_cmd.keep_y = KEEP_NONE;
                    o_cmd.set_y  = f_hi(w_d[0]) | f_lo(w_d[1]);
                    o_cmd.keep_x = KEEP_NONE;
                    o_cmd.set_x  = f_hi(w_d[2]) | f_lo(w_d[3]);
                end
                TAG_HY_LX: begin
                    o_cmd.keep_y = KEEP_NO_HI;
                    o_cmd.set_y  = f_hi(w_d[0]);
                    o_cmd.keep_x = KEEP_NO_LO;
                    o_cmd.set_x  = f_lo(w_d[1]);
                end
                TAG_LY_LX: begin
                    o_cmd.keep_y = KEEP_NO_LO;
                    o_cmd.set_y  = f_lo(w_d[0]);
                    o_cmd.keep_x = KEEP_NO_LO;
                    o_cmd.set_x  = f_lo(w_d[1]);
                end
                TAG_LY_HX_LX: begin
                    o_cmd.keep_y = KEEP_NO_LO;
                    o_cmd.set_y  = f_lo(w_d[0]);
                    o_cmd.keep_x = KEEP_EX;
                    o_cmd.set_x  = f_hi(w_d[1]) | f_lo(w_d[2]);
                end
                TAG_LX: begin
                    o_cmd.keep_x = KEEP_NO_LO;
                    o_cmd.set_x  = f_lo(w_d[0]);
                end
                TAG_EX_LY_LX: begin
                    o_cmd.keep_y = KEEP_HI;
                    o_cmd.set_y  = f_lo(w_d[1]) | f_ex_y(w_d[0]);
                    o_cmd.keep_x = KEEP_HI;
                    o_cmd.set_x  = f_lo(w_d[2]) | f_ex_x(w_d[0]);
                end
                TAG_HY_LY_LX: begin
                    o_cmd.keep_y = KEEP_EX;
                    o_cmd.set_y  = f_hi(w_d[0]) | f_lo(w_d[1]);
                    o_cmd.keep_x = KEEP_NO_LO;
                    o_cmd.set_x  = f_lo(w_d[2]);
                end
                TAG_EX_LY_HX_LX: begin
                    o_cmd.keep_y = KEEP_HI;
                    o_cmd.set_y  = f_lo(w_d[1]) | f_ex_y(w_d[0]);
                    o_cmd.keep_x = KEEP_NONE;
                    o_cmd.set_x  = f_hi(w_d[2]) | f_lo(w_d[3]) | f_ex_x(w_d[0]);
                end
                TAG_HY_EX_LY_LX: begin
                    o_cmd.keep_y = KEEP_NONE;
                    o_cmd.set_y  = f_hi(w_d[0]) | f_lo(w_d[2]) | f_ex_y(w_d[1]);
                    o_cmd.keep_x = KEEP_HI;
                    o_cmd.set_x  = f_lo(w_d[3]) | f_ex_x(w_d[1]);
                end
                TAG_HY_HX_LX: begin
                    o_cmd.keep_y = KEEP_NO_HI;
                    o_cmd.set_y  = f_hi(w_d[0]);
                    o_cmd.keep_x = KEEP_EX;
                    o_cmd.set_x  = f_hi(w_d[1]) | f_lo(w_d[2]);
                end
                default: begin
                    o_cmd.op = vad_pkg::CMD_BAD;
                end
            endcase
        end
    end

    // Hand the request straight to the queue
    assign o_cmd_valid = i_req.valid;
    assign i_req.ready = i_cmd_ready;

endmodule

// ===== rtl/vad_queue.sv =====
// ----------------------------------------------------------------------------
// Vector address decoder command queue
// Small first-in first-out store between the decode front and the back.
// ----------------------------------------------------------------------------
module vad_queue #(
    parameter int DEPTH = vad_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  vad_pkg::t_cmd   i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output vad_pkg::t_cmd   o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vad_pkg::t_cmd     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              w_push;
    logic              w_pop;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Store pushed requests
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
        end
    end

endmodule

// ===== rtl/vad_back.sv =====
// ----------------------------------------------------------------------------
// Vector address decoder back
// Holds the beam position and the configuration registers, carries out each
// queued command and presents the display record from an output register.
// ----------------------------------------------------------------------------
module vad_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  vad_pkg::t_cmd   i_cmd,
    vad_cfg_if.sink         i_cfg,
    vad_res_if.source       o_res
);

    localparam int PW = vad_pkg::POS_W;

    logic                                r_pen_down;
    logic [vad_pkg::INTEN_W-1:0]         r_intensity;
    logic [vad_pkg::STYLE_W-1:0]         r_line_style;
    logic                                r_defocus;
    logic                                r_through_mode;
    logic [vad_pkg::GLOW_W-1:0]          r_normal_glow;
    logic [vad_pkg::GLOW_W-1:0]          r_through_glow;

    logic [PW-1:0]                       r_beam_y;
    logic [PW-1:0]                       r_beam_x;
    logic [PW-1:0]                       n_beam_y;
    logic [PW-1:0]                       n_beam_x;

    logic                                r_out_valid;
    vad_pkg::t_rec                       r_rec;
    vad_pkg::t_rec                       n_rec;

    logic                                w_pop;
    logic                                w_cfg_wr;
    logic [vad_pkg::STYLE_W-1:0]         w_style;
    logic [vad_pkg::GLOW_W-1:0]          w_glow;

    // Take a command whenever the output register is free or being drained
    assign o_cmd_ready = !r_out_valid || o_res.ready;
    assign w_pop       = i_cmd_valid && o_cmd_ready;

    assign w_style = (r_line_style > vad_pkg::STYLE_MAX) ? '0 : r_line_style;
    assign w_glow  = r_through_mode ? r_through_glow : r_normal_glow;

    // Work out the next position and the record
    always_comb begin
        n_beam_y = r_beam_y;
        n_beam_x = r_beam_x;
        n_rec.valid_res     = 1'b1;
        n_rec.kind          = i_cmd.kind;
        n_rec.intensity     = r_intensity;
        n_rec.style         = w_style;
        n_rec.glow          = w_glow;
        n_rec.defocus       = r_defocus;
        n_rec.through_mode  = r_through_mode;
        case (i_cmd.op)
            vad_pkg::CMD_STEP: begin
                if (i_cmd.dir[3] && !i_cmd.dir[2]) begin
                    n_beam_y = r_beam_y - 1'b1;
                end else if (i_cmd.dir[2] && !i_cmd.dir[3]) begin
                    n_beam_y = r_beam_y + 1'b1;
                end
                if (i_cmd.dir[1] && !i_cmd.dir[0]) begin
                    n_beam_x = r_beam_x - 1'b1;
                end else if (i_cmd.dir[0] && !i_cmd.dir[1]) begin
                    n_beam_x = r_beam_x + 1'b1;
                end
                n_rec.kind  = r_pen_down ? vad_pkg::KIND_POINT : vad_pkg::KIND_MOVE;
                n_rec.style = '0;
                if (!r_pen_down) begin
                    n_rec.intensity = '0;
                end
            end
            vad_pkg::CMD_ADDR: begin
                n_beam_y = (r_beam_y & i_cmd.keep_y) | i_cmd.set_y;
                n_beam_x = (r_beam_x & i_cmd.keep_x) | i_cmd.set_x;
            end
            default: begin
                n_rec.valid_res     = 1'b0;
                n_rec.kind          = '0;
                n_rec.intensity     = '0;
                n_rec.style         = '0;
                n_rec.glow          = '0;
                n_rec.defocus       = 1'b0;
                n_rec.through_mode  = 1'b0;
            end
        endcase
        n_rec.pos_y = n_beam_y;
        n_rec.pos_x = n_beam_x;
    end

    // Hold position and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam_y    <= vad_pkg::HOME_Y;
            r_beam_x    <= vad_pkg::HOME_X;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_beam_y    <= n_beam_y;
                r_beam_x    <= n_beam_x;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_rec <= n_rec;
        end
    end

    // Configuration writes
    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_down      <= 1'b0;
            r_intensity     <= vad_pkg::RST_INTENSITY;
            r_line_style    <= '0;
            r_defocus       <= 1'b0;
            r_through_mode  <= 1'b0;
            r_normal_glow   <= vad_pkg::RST_NORMAL_GLOW;
            r_through_glow  <= vad_pkg::RST_THROUGH_GLOW;
        end else if (w_cfg_wr) begin
            case (i_cfg.index)
                vad_pkg::CFG_PEN_DOWN:      r_pen_down      <= i_cfg.data[0];
                vad_pkg::CFG_INTENSITY:     r_intensity     <= i_cfg.data[vad_pkg::INTEN_W-1:0];
                vad_pkg::CFG_LINE_STYLE:    r_line_style    <= i_cfg.data[vad_pkg::STYLE_W-1:0];
                vad_pkg::CFG_DEFOCUS:       r_defocus       <= i_cfg.data[0];
                vad_pkg::CFG_THROUGH_MODE:  r_through_mode  <= i_cfg.data[0];
                vad_pkg::CFG_NORMAL_GLOW:   r_normal_glow   <= i_cfg.data;
                vad_pkg::CFG_THROUGH_GLOW:  r_through_glow  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Drive the result channel
    assign o_res.valid             = r_out_valid;
    assign o_res.valid_res         = r_rec.valid_res;
    assign o_res.kind              = r_rec.kind;
    assign o_res.pos_y             = r_rec.pos_y;
    assign o_res.pos_x             = r_rec.pos_x;
    assign o_res.rec_intensity     = r_rec.intensity;
    assign o_res.rec_style         = r_rec.style;
    assign o_res.glow_count        = r_rec.glow;
    assign o_res.rec_defocus       = r_rec.defocus;
    assign o_res.rec_through_mode  = r_rec.through_mode;

`ifndef SYNTHESIS
    // An unrecognised group leaves the beam where it was
    a_bad_keeps_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && (i_cmd.op == vad_pkg::CMD_BAD))
        |=> (r_beam_y == $past(r_beam_y)) && (r_beam_x == $past(r_beam_x)))
        else $error("beam moved on an unrecognised group");

    // An invalid record carries no attributes
    a_bad_rec_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_rec.valid_res)
        |-> (r_rec.kind == '0) && (r_rec.intensity == '0) && (r_rec.style == '0)
            && (r_rec.glow == '0) && !r_rec.defocus && !r_rec.through_mode)
        else $error("invalid record carries attributes");

    // The presented position is always the current beam position
    a_rec_tracks_beam: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_rec.pos_y == r_beam_y) && (r_rec.pos_x == r_beam_x))
        else $error("record position differs from beam register");

    // Styles above STYLE_MAX never leave the block
    a_style_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_rec.style <= vad_pkg::STYLE_MAX))
        else $error("line style out of range in record");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vector address decoder regression
// Drives address groups and step requests through the request channel,
// predicts every display record from a behavioural copy of the beam position
// and register file, and checks each record in order as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;
    import vad_pkg::*;

    // Request opcodes
    localparam logic OP_ADDR = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Record kinds not named in the package
    localparam logic [KIND_W-1:0] KIND_DRAW    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SPECIAL = 2'd3;

    // Step direction bits
    localparam int DIR_Y_DEC = 3;
    localparam int DIR_Y_INC = 2;
    localparam int DIR_X_DEC = 1;
    localparam int DIR_X_INC = 0;

    // Per-byte tags: none, high field, low x, low y or extra
    localparam logic [1:0] BT_NONE = 2'b00;
    localparam logic [1:0] BT_HIGH = 2'b01;
    localparam logic [1:0] BT_LOWX = 2'b10;
    localparam logic [1:0] BT_LOW  = 2'b11;

    // Recognised tag patterns
    localparam logic [TAG_W-1:0] TAG_FULL_LOAD   = 10'h1F6;
    localparam logic [TAG_W-1:0] TAG_TEN_LOAD    = 10'h076;
    localparam logic [TAG_W-1:0] TAG_HIY_LOX     = 10'h006;
    localparam logic [TAG_W-1:0] TAG_LOY_LOX     = 10'h00E;
    localparam logic [TAG_W-1:0] TAG_LOY_X       = 10'h036;
    localparam logic [TAG_W-1:0] TAG_LOX         = 10'h002;
    localparam logic [TAG_W-1:0] TAG_EXT_LOY_LOX = 10'h03E;
    localparam logic [TAG_W-1:0] TAG_Y_LOX       = 10'h01E;
    localparam logic [TAG_W-1:0] TAG_EXT_LOY_X   = 10'h0F6;
    localparam logic [TAG_W-1:0] TAG_Y_EXT_LOX   = 10'h07E;
    localparam logic [TAG_W-1:0] TAG_HIY_X       = 10'h016;

    localparam logic [TAG_W-1:0] PATTERN_TAG [11] = '{
        TAG_FULL_LOAD, TAG_TEN_LOAD, TAG_HIY_LOX, TAG_LOY_LOX, TAG_LOY_X, TAG_LOX,
        TAG_EXT_LOY_LOX, TAG_Y_LOX, TAG_EXT_LOY_X, TAG_Y_EXT_LOX, TAG_HIY_X
    };
    localparam int PATTERN_LEN [11] = '{5, 4, 2, 2, 3, 1, 3, 3, 4, 4, 3};

    // Unused register index
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 75;
    localparam int DRAIN_EVERY  = 97;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 10;

    typedef struct packed {
        logic                        opcode;
        logic [COUNT_W-1:0]          byte_count;
        logic [4:0][BYTE_W-1:0]      addr_bytes;
        logic [DIR_W-1:0]            step_dir;
        logic [KIND_W-1:0]           vector_kind;
    } t_req;

    logic clk;
    logic rst_n;

    vad_req_if req_if ();
    vad_cfg_if cfg_if ();
    vad_res_if res_if ();

    vector_address_decoder u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // Behavioural beam position and register copies
    logic [POS_W-1:0]   cur_y = HOME_Y;
    logic [POS_W-1:0]   cur_x = HOME_X;
    logic               pen_on = 1'b0;
    logic [INTEN_W-1:0] inten_set = RST_INTENSITY;
    logic [STYLE_W-1:0] style_set = '0;
    logic               defocus_set = 1'b0;
    logic               wthru_set = 1'b0;
    logic [GLOW_W-1:0]  glow_normal = RST_NORMAL_GLOW;
    logic [GLOW_W-1:0]  glow_through = RST_THROUGH_GLOW;

    t_req request_queue [$];
    t_rec due_records [$];
    t_req drive_req;
    t_rec got_rec;
    t_rec want_rec;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   mismatches     = 0;
    int   quiet_cycles   = 0;
    int   sent_count     = 0;
    logic req_taken      = 1'b0;
    logic drain_hold     = 1'b0;

    // Clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Work out the display record of one request and advance the beam
    function automatic t_rec decode_request(input t_req r);
        logic [POS_W-1:0]  ny;
        logic [POS_W-1:0]  nx;
        logic [DATA_W-1:0] d0, d1, d2, d3, d4;
        logic [TAG_W-1:0]  tag;
        logic              known;
        t_rec              rec;
        ny  = cur_y;
        nx  = cur_x;
        rec = '0;
        if (r.opcode == OP_STEP) begin
            // Opposite bits cancel; 12-bit arithmetic wraps on its own
            if (r.step_dir[DIR_Y_DEC]) ny = ny - 1'b1;
            if (r.step_dir[DIR_Y_INC]) ny = ny + 1'b1;
            if (r.step_dir[DIR_X_DEC]) nx = nx - 1'b1;
            if (r.step_dir[DIR_X_INC]) nx = nx + 1'b1;
            cur_y         = ny;
            cur_x         = nx;
            rec.valid_res = 1'b1;
            rec.kind      = pen_on ? KIND_POINT : KIND_MOVE;
            rec.intensity = pen_on ? inten_set : '0;
        end else begin
            d0 = r.addr_bytes[0][DATA_W-1:0];
            d1 = r.addr_bytes[1][DATA_W-1:0];
            d2 = r.addr_bytes[2][DATA_W-1:0];
            d3 = r.addr_bytes[3][DATA_W-1:0];
            d4 = r.addr_bytes[4][DATA_W-1:0];
            tag = '0;
            for (int i = 0; i < 5 && i < r.byte_count; i++)
                tag = {tag[TAG_W-3:0], r.addr_bytes[i][BYTE_W-1:DATA_W]};
            known = (r.byte_count >= 1 && r.byte_count <= 5);
            // Extra byte: bits 4:2 fold into y bits 2:0, bits 1:0 give x bits 1:0
            case (tag)
                TAG_FULL_LOAD: begin
                    ny = {d0, d2, 2'b00} | {9'd0, d1[4:2]};
                    nx = {d3, d4, d1[1:0]};
                end
                TAG_TEN_LOAD: begin
                    ny = {d0, d1, 2'b00};
                    nx = {d2, d3, 2'b00};
                end
                TAG_HIY_LOX: begin
                    ny = {d0, ny[6:0]};
                    nx = {nx[11:7], d1, nx[1:0]};
                end
                TAG_LOY_LOX: begin
                    ny = {ny[11:7], d0, ny[1:0]};
                    nx = {nx[11:7], d1, nx[1:0]};
                end
                TAG_LOY_X: begin
                    ny = {ny[11:7], d0, ny[1:0]};
                    nx = {d1, d2, nx[1:0]};
                end
                TAG_LOX: begin
                    nx = {nx[11:7], d0, nx[1:0]};
                end
                TAG_EXT_LOY_LOX: begin
                    ny = {ny[11:7], d1, 2'b00} | {9'd0, d0[4:2]};
                    nx = {nx[11:7], d2, d0[1:0]};
                end
                TAG_Y_LOX: begin
                    ny = {d0, d1, ny[1:0]};
                    nx = {nx[11:7], d2, nx[1:0]};
                end
                TAG_EXT_LOY_X: begin
                    ny = {ny[11:7], d1, 2'b00} | {9'd0, d0[4:2]};
                    nx = {d2, d3, d0[1:0]};
                end
                TAG_Y_EXT_LOX: begin
                    ny = {d0, d2, 2'b00} | {9'd0, d1[4:2]};
                    nx = {nx[11:7], d3, d1[1:0]};
                end
                TAG_HIY_X: begin
                    ny = {d0, ny[6:0]};
                    nx = {d1, d2, nx[1:0]};
                end
                default: begin
                    known = 1'b0;
                end
            endcase
            if (!known) begin
                // Unknown pattern: report the unchanged position only
                rec.pos_y = cur_y;
                rec.pos_x = cur_x;
                return rec;
            end
            cur_y         = ny;
            cur_x         = nx;
            rec.valid_res = 1'b1;
            rec.kind      = r.vector_kind;
            rec.intensity = inten_set;
            rec.style     = (style_set > STYLE_MAX) ? '0 : style_set;
        end
        rec.pos_y         = cur_y;
        rec.pos_x         = cur_x;
        rec.glow          = wthru_set ? glow_through : glow_normal;
        rec.defocus       = defocus_set;
        rec.through_mode  = wthru_set;
        return rec;
    endfunction

    // Mirror one register write
    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_PEN_DOWN:      pen_on       = data[0];
            CFG_INTENSITY:     inten_set    = data[INTEN_W-1:0];
            CFG_LINE_STYLE:    style_set    = data[STYLE_W-1:0];
            CFG_DEFOCUS:       defocus_set  = data[0];
            CFG_THROUGH_MODE:  wthru_set    = data[0];
            CFG_NORMAL_GLOW:   glow_normal  = data;
            CFG_THROUGH_GLOW:  glow_through = data;
            default: ;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] ab(input logic [1:0] tag, input logic [4:0] data);
        return {tag, data};
    endfunction

    function automatic t_req addr_req(input logic [COUNT_W-1:0] cnt,
                                      input logic [BYTE_W-1:0] b0, b1, b2, b3, b4,
                                      input logic [KIND_W-1:0] kind);
        t_req r;
        r.opcode      = OP_ADDR;
        r.byte_count  = cnt;
        r.addr_bytes  = {b4, b3, b2, b1, b0};
        r.step_dir    = DIR_W'($urandom_range(15));
        r.vector_kind = kind;
        return r;
    endfunction

    // Step with junk in every field that a step ignores
    function automatic t_req step_req(input logic [DIR_W-1:0] dir);
        t_req r;
        r.opcode      = OP_STEP;
        r.byte_count  = COUNT_W'($urandom_range(7));
        for (int i = 0; i < 5; i++)
            r.addr_bytes[i] = BYTE_W'($urandom_range(127));
        r.step_dir    = dir;
        r.vector_kind = KIND_W'($urandom_range(3));
        return r;
    endfunction

    // Mostly well-formed groups, some steps, some raw noise
    function automatic t_req random_request();
        t_req r;
        int   sel;
        int   pick;
        int   len;
        int   lead;
        r   = step_req(DIR_W'($urandom_range(15)));
        sel = $urandom_range(99);
        if (sel >= 30) begin
            r.opcode = OP_ADDR;
        end
        if (sel >= 45) begin
            pick = $urandom_range(10);
            len  = PATTERN_LEN[pick];
            lead = ($urandom_range(3) == 0) ? $urandom_range(5 - len) : 0;
            for (int i = 0; i < lead; i++)
                r.addr_bytes[i][BYTE_W-1:DATA_W] = BT_NONE;
            for (int i = 0; i < len; i++)
                r.addr_bytes[lead + i][BYTE_W-1:DATA_W] =
                    2'(PATTERN_TAG[pick] >> (2 * (len - 1 - i)));
            r.byte_count = COUNT_W'(len + lead);
        end
        return r;
    endfunction

    // Random register value
    function automatic logic [CFG_DATA_W-1:0] rnd_val(input int unsigned hi);
        return CFG_DATA_W'($urandom_range(hi));
    endfunction

    // Register write; valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
    endtask

    task automatic program_registers(input logic [CFG_DATA_W-1:0] pen, inten, style,
                                     input logic [CFG_DATA_W-1:0] defocus, wthru,
                                     input logic [CFG_DATA_W-1:0] nglow, tglow);
        write_reg(CFG_PEN_DOWN, pen);
        write_reg(CFG_INTENSITY, inten);
        write_reg(CFG_LINE_STYLE, style);
        write_reg(CFG_DEFOCUS, defocus);
        write_reg(CFG_THROUGH_MODE, wthru);
        write_reg(CFG_NORMAL_GLOW, nglow);
        write_reg(CFG_THROUGH_GLOW, tglow);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Hold until no request is pending or in flight and every record is in
    task automatic wait_drained();
        do @(posedge clk);
        while (request_queue.size() != 0 || req_if.valid || due_records.size() != 0);
    endtask

    // Stimulus and phase control
    initial begin
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.opcode      = OP_ADDR;
        req_if.byte_count  = '0;
        req_if.addr_byte0  = '0;
        req_if.addr_byte1  = '0;
        req_if.addr_byte2  = '0;
        req_if.addr_byte3  = '0;
        req_if.addr_byte4  = '0;
        req_if.step_dir    = '0;
        req_if.vector_kind = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        res_if.ready       = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests under the reset register values
        request_queue.push_back(step_req(4'b0000));
        request_queue.push_back(addr_req(3'd5, ab(BT_HIGH, 5'h1F), ab(BT_LOW, 5'h1F),
            ab(BT_LOW, 5'h1F), ab(BT_HIGH, 5'h1F), ab(BT_LOWX, 5'h1F), KIND_SPECIAL));
        request_queue.push_back(step_req(4'b0101));
        request_queue.push_back(step_req(4'b1010));
        request_queue.push_back(step_req(4'b1111));
        request_queue.push_back(addr_req(3'd4, ab(BT_HIGH, 5'h00), ab(BT_LOW, 5'h00),
            ab(BT_HIGH, 5'h00), ab(BT_LOWX, 5'h00), 7'h7F, KIND_MOVE));
        request_queue.push_back(addr_req(3'd2, ab(BT_HIGH, 5'h15), ab(BT_LOWX, 5'h0A),
            7'h00, 7'h00, 7'h00, KIND_DRAW));
        request_queue.push_back(addr_req(3'd2, ab(BT_LOW, 5'h1F), ab(BT_LOWX, 5'h11),
            7'h00, 7'h00, 7'h00, KIND_POINT));
        request_queue.push_back(addr_req(3'd3, ab(BT_LOW, 5'h03), ab(BT_HIGH, 5'h1C),
            ab(BT_LOWX, 5'h07), 7'h00, 7'h00, KIND_SPECIAL));
        request_queue.push_back(addr_req(3'd1, ab(BT_LOWX, 5'h1E), 7'h00, 7'h00,
            7'h00, 7'h00, KIND_DRAW));
        request_queue.push_back(addr_req(3'd3, ab(BT_LOW, 5'h1F), ab(BT_LOW, 5'h0C),
            ab(BT_LOWX, 5'h13), 7'h00, 7'h00, KIND_POINT));
        request_queue.push_back(addr_req(3'd3, ab(BT_HIGH, 5'h09), ab(BT_LOW, 5'h16),
            ab(BT_LOWX, 5'h05), 7'h00, 7'h00, KIND_DRAW));
        request_queue.push_back(addr_req(3'd4, ab(BT_LOW, 5'h0A), ab(BT_LOW, 5'h1B),
            ab(BT_HIGH, 5'h02), ab(BT_LOWX, 5'h18), 7'h00, KIND_MOVE));
        request_queue.push_back(addr_req(3'd4, ab(BT_HIGH, 5'h11), ab(BT_LOW, 5'h05),
            ab(BT_LOW, 5'h0E), ab(BT_LOWX, 5'h1D), 7'h00, KIND_DRAW));
        request_queue.push_back(addr_req(3'd3, ab(BT_HIGH, 5'h1F), ab(BT_HIGH, 5'h00),
            ab(BT_LOWX, 5'h1F), 7'h00, 7'h00, KIND_POINT));
        // Unknown patterns
        request_queue.push_back(addr_req(3'd1, ab(BT_LOW, 5'h0F), 7'h00, 7'h00,
            7'h00, 7'h00, KIND_DRAW));
        request_queue.push_back(addr_req(3'd5, ab(BT_LOW, 5'h1F), ab(BT_LOW, 5'h1F),
            ab(BT_LOW, 5'h1F), ab(BT_LOW, 5'h1F), ab(BT_LOW, 5'h1F), KIND_SPECIAL));
        // Leading empty tag
        request_queue.push_back(addr_req(3'd3, ab(BT_NONE, 5'h1F), ab(BT_HIGH, 5'h06),
            ab(BT_LOWX, 5'h19), 7'h00, 7'h00, KIND_DRAW));
        // Byte counts out of range
        request_queue.push_back(addr_req(3'd0, ab(BT_LOWX, 5'h04), 7'h00, 7'h00,
            7'h00, 7'h00, KIND_DRAW));
        request_queue.push_back(addr_req(3'd6, ab(BT_NONE, 5'h00), ab(BT_HIGH, 5'h1F),
            ab(BT_LOW, 5'h1F), ab(BT_HIGH, 5'h1F), ab(BT_LOWX, 5'h1F), KIND_DRAW));
        request_queue.push_back(addr_req(3'd7, ab(BT_LOWX, 5'h1F), 7'h7F, 7'h7F,
            7'h7F, 7'h7F, KIND_POINT));
        // Junk past the count
        request_queue.push_back(addr_req(3'd2, ab(BT_HIGH, 5'h04), ab(BT_LOWX, 5'h08),
            7'h7F, 7'h7F, 7'h7F, KIND_SPECIAL));
        request_queue.push_back(step_req(4'b0110));

        // Random phases over register settings and idle patterns
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: program_registers(8'd1, 8'd127, 8'd4, 8'd1, 8'd1, 8'd255, 8'd255);
                1: program_registers(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                2: program_registers(rnd_val(255), rnd_val(255),
                       {5'($urandom_range(31)), 3'($urandom_range(5, 7))},
                       rnd_val(255), rnd_val(255), rnd_val(255), rnd_val(255));
                3: program_registers(8'd1, rnd_val(255), rnd_val(4), rnd_val(1), 8'd0,
                       rnd_val(255), rnd_val(255));
                default: begin
                    if (phase == 4)
                        write_reg(CFG_SPARE, rnd_val(255));
                    program_registers(rnd_val(255), rnd_val(255), rnd_val(255),
                        rnd_val(255), rnd_val(255), rnd_val(255), rnd_val(255));
                end
            endcase
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 62;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 62;
                end
                default: begin
                    send_idle_pct  = 19;
                    recv_stall_pct = 19;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                request_queue.push_back(random_request());
        end

        wait_drained();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatches == 0 && due_records.size() == 0) begin
            $display("vector_address_decoder regression: pass");
        end else begin
            $display("vector_address_decoder regression: fail");
        end
        $finish;
    end

    // Request driver: present the next request once the current one is taken
    always @(negedge clk) begin
        if (rst_n) begin
            if (!req_if.valid || req_taken) begin
                if (drain_hold && due_records.size() == 0)
                    drain_hold = 1'b0;
                if (request_queue.size() != 0 && !drain_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    drive_req = request_queue.pop_front();
                    req_if.valid       <= 1'b1;
                    req_if.opcode      <= drive_req.opcode;
                    req_if.byte_count  <= drive_req.byte_count;
                    req_if.addr_byte0  <= drive_req.addr_bytes[0];
                    req_if.addr_byte1  <= drive_req.addr_bytes[1];
                    req_if.addr_byte2  <= drive_req.addr_bytes[2];
                    req_if.addr_byte3  <= drive_req.addr_bytes[3];
                    req_if.addr_byte4  <= drive_req.addr_bytes[4];
                    req_if.step_dir    <= drive_req.step_dir;
                    req_if.vector_kind <= drive_req.vector_kind;
                    sent_count++;
                    // Now and then hold off until every record is back
                    if (sent_count % DRAIN_EVERY == 0)
                        drain_hold = 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            req_taken = 1'b0;
        end
    end

    // Record receiver back-pressure
    always @(negedge clk) begin
        if (rst_n) begin
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: mirror register writes, predict on intake, check on output
    always @(posedge clk) begin
        quiet_cycles++;
        if (rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                quiet_cycles = 0;
                apply_register(cfg_if.index, cfg_if.data);
            end
            if (req_if.valid && req_if.ready) begin
                quiet_cycles = 0;
                req_taken    = 1'b1;
                due_records.push_back(decode_request('{
                    opcode:      req_if.opcode,
                    byte_count:  req_if.byte_count,
                    addr_bytes:  {req_if.addr_byte4, req_if.addr_byte3, req_if.addr_byte2,
                                  req_if.addr_byte1, req_if.addr_byte0},
                    step_dir:    req_if.step_dir,
                    vector_kind: req_if.vector_kind}));
            end
            if (res_if.valid && res_if.ready) begin
                quiet_cycles = 0;
                got_rec = '{
                    valid_res:     res_if.valid_res,
                    kind:          res_if.kind,
                    pos_y:         res_if.pos_y,
                    pos_x:         res_if.pos_x,
                    intensity:     res_if.rec_intensity,
                    style:         res_if.rec_style,
                    glow:          res_if.glow_count,
                    defocus:       res_if.rec_defocus,
                    through_mode:  res_if.rec_through_mode};
                if (due_records.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("record with no request behind it: y=%0d x=%0d",
                                 got_rec.pos_y, got_rec.pos_x);
                end else begin
                    want_rec = due_records.pop_front();
                    if (got_rec !== want_rec) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("record mismatch at %0t", $realtime);
                            $display({"  expected v=%0d k=%0d y=%0d x=%0d i=%0d",
                                      " s=%0d g=%0d d=%0d w=%0d"},
                                want_rec.valid_res, want_rec.kind, want_rec.pos_y,
                                want_rec.pos_x, want_rec.intensity, want_rec.style,
                                want_rec.glow, want_rec.defocus, want_rec.through_mode);
                            $display({"  actual   v=%0d k=%0d y=%0d x=%0d i=%0d",
                                      " s=%0d g=%0d d=%0d w=%0d"},
                                got_rec.valid_res, got_rec.kind, got_rec.pos_y,
                                got_rec.pos_x, got_rec.intensity, got_rec.style,
                                got_rec.glow, got_rec.defocus, got_rec.through_mode);
                        end
                    end
                end
            end
        end
        // Watchdog: drop the run after a long stretch with no handshake
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("vector_address_decoder regression: fail");
            $finish;
        end
    end

endmodule
